[hw/rtl/linked_task_list_manager_top_defines.svh]
// Assertion macros for the task list manager
`ifndef LINKED_TASK_LIST_MANAGER_TOP_DEFINES_SVH
`define LINKED_TASK_LIST_MANAGER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define LTLM_ASSERT_IMP(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define LTLM_ASSERT_NXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define LTLM_ASSERT_IMP(label, clk, rst_n, a, c)
`define LTLM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

[hw/rtl/ltlm_pkg.sv]
package ltlm_pkg;
	localparam logic [1:0] REQ_APPEND = 2'd0;
	localparam logic [1:0] REQ_POP    = 2'd1;
	localparam logic [1:0] REQ_UNLINK = 2'd2;
	localparam logic [1:0] REQ_ADMIT  = 2'd3;

	localparam logic [1:0] KIND_READY = 2'd0;

	localparam int REQ_W   = 2;
	localparam int KIND_W  = 2;
	localparam int CPUF_W  = 3;
	localparam int ENTF_W  = 6;
	localparam int COUNT_W = 32;
endpackage

[hw/rtl/linked_task_list_manager_top.sv]
// Task list manager: singly linked lists threaded through a pool of entries.
// Channels: in (in_valid/in_ready: req_type, list_kind, cpu_index,
// entry_index), out (out_valid/out_ready: found, entry_out, chosen_cpu),
// cfg (cfg_valid/cfg_ready: cfg_data = balance_enable).
// One result per request. The block takes one request at a time.
// Append and unlink walk the list through the link memory, entry by
// entry. Balanced admit first scans the admission counters, one CPU per
// cycle. After reset the link memory is initialized, one entry per cycle,
// before in_ready rises; all entries start on the free list. A held
// result sits in the output register; a stalled receiver keeps in_ready
// low until the result is taken.
`include "linked_task_list_manager_top_defines.svh"
module linked_task_list_manager_top #(
	parameter int NUM_ENTRIES = 64,
	parameter int NUM_CPUS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  logic [ltlm_pkg::REQ_W-1:0] req_type,
	input  logic [ltlm_pkg::KIND_W-1:0] list_kind,
	input  logic [ltlm_pkg::CPUF_W-1:0] cpu_index,
	input  logic [ltlm_pkg::ENTF_W-1:0] entry_index,
	output logic out_valid,
	input  logic out_ready,
	output logic found,
	output logic [ltlm_pkg::ENTF_W-1:0] entry_out,
	output logic [ltlm_pkg::CPUF_W-1:0] chosen_cpu,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);
	localparam int LW = $clog2(NUM_ENTRIES+1);
	localparam int CW = $clog2(NUM_CPUS+1);
	localparam int SW = $clog2(NUM_CPUS+3);

	localparam logic [2:0] T_IDLE = 3'd0;
	localparam logic [2:0] T_SCAN = 3'd1;
	localparam logic [2:0] T_LIST = 3'd2;
	localparam logic [2:0] T_WAIT = 3'd3;
	localparam logic [2:0] T_OUT  = 3'd4;

	logic [2:0] st_q;
	logic bal_q;
	logic [1:0] req_q;
	logic [1:0] kind_q;
	logic [CW-1:0] cpu_q;
	logic [LW-1:0] ent_q;
	logic [ltlm_pkg::ENTF_W-1:0] ent_raw_q;
	logic found_q;
	logic [ltlm_pkg::ENTF_W-1:0] eout_q;
	logic [ltlm_pkg::CPUF_W-1:0] chosen_q;
	logic eng_start, eng_done, eng_ok;
	logic [LW-1:0] eng_pop;
	logic [SW-1:0] eng_slot;
	logic min_start, min_busy, inc;
	logic [CW-1:0] best_cpu, scan_cpu;
	logic eng_idle_q;
	logic [CW-1:0] tgt_q;
	logic [LW:0] init_cnt_q;
	logic u_eng_ready_w;

	assign in_ready  = (st_q == T_IDLE) && eng_idle_q;
	assign cfg_ready = 1'b1;
	assign out_valid = (st_q == T_OUT);
	assign found     = found_q;
	assign entry_out = eout_q;
	assign chosen_cpu = chosen_q;

	ltlm_min_finder #(.NUM_CPUS(NUM_CPUS)) u_min (
		.clk(clk), .arst_n(arst_n), .start(min_start), .count_in('0),
		.inc(inc), .inc_cpu(tgt_q), .scan_cpu(scan_cpu), .busy(min_busy),
		.best_cpu(best_cpu)
	);

	ltlm_list_engine #(.NUM_ENTRIES(NUM_ENTRIES), .NUM_CPUS(NUM_CPUS)) u_eng (
		.clk(clk), .arst_n(arst_n), .start(eng_start), .op(req_q), .slot(eng_slot),
		.ent(ent_q), .done(eng_done), .ok(eng_ok), .popped(eng_pop)
	);

	always_comb begin
		if (req_q == ltlm_pkg::REQ_ADMIT || kind_q == ltlm_pkg::KIND_READY)
			eng_slot = SW'(tgt_q);
		else eng_slot = SW'(NUM_CPUS) + SW'(kind_q) - 1'b1;
	end

	assign eng_start = (st_q == T_LIST);
	assign inc = eng_done && eng_ok && (req_q == ltlm_pkg::REQ_ADMIT);
	assign min_start = in_valid && in_ready && cfg_data_dummy();

	function automatic logic cfg_data_dummy();
		return bal_q && req_type == ltlm_pkg::REQ_ADMIT;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= T_IDLE;
			bal_q <= 1'b0;
			eng_idle_q <= 1'b0;
			found_q <= 1'b0;
			eout_q <= '0;
			chosen_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) bal_q <= cfg_data;
			if (!eng_idle_q) eng_idle_q <= (u_eng_ready_w == 1'b1);
			unique case (st_q)
				T_IDLE: if (in_valid && in_ready) begin
					req_q <= req_type;
					kind_q <= list_kind;
					cpu_q <= CW'(cpu_index);
					tgt_q <= CW'(cpu_index);
					ent_raw_q <= entry_index;
					ent_q <= LW'(entry_index);
					found_q <= 1'b0;
					chosen_q <= '0;
					eout_q <= (req_type == ltlm_pkg::REQ_POP) ? '0 : entry_index;
					if (req_type != ltlm_pkg::REQ_POP && {26'd0, entry_index} >= 32'(NUM_ENTRIES))
						st_q <= T_OUT;
					else if (req_type == ltlm_pkg::REQ_ADMIT && bal_q)
						st_q <= T_SCAN;
					else if ((req_type == ltlm_pkg::REQ_ADMIT || list_kind == ltlm_pkg::KIND_READY)
						&& {29'd0, cpu_index} >= 32'(NUM_CPUS))
						st_q <= T_OUT;
					else st_q <= T_LIST;
				end
				T_SCAN: if (!min_busy && !min_start) begin
					tgt_q <= best_cpu;
					st_q <= T_LIST;
				end
				T_LIST: st_q <= T_WAIT;
				T_WAIT: if (eng_done) begin
					found_q <= eng_ok;
					if (req_q == ltlm_pkg::REQ_POP)
						eout_q <= eng_ok ? eng_pop[ltlm_pkg::ENTF_W-1:0] : '0;
					if (inc) chosen_q <= tgt_q[ltlm_pkg::CPUF_W-1:0];
					st_q <= T_OUT;
				end
				T_OUT: if (out_ready) st_q <= T_IDLE;
				default: st_q <= T_IDLE;
			endcase
		end
	end

	// tracks the engine's memory init; ready once the count reaches NUM_ENTRIES
	assign u_eng_ready_w = (init_cnt_q >= (LW+1)'(NUM_ENTRIES));
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) init_cnt_q <= '0;
		else if (!u_eng_ready_w) init_cnt_q <= init_cnt_q + 1'b1;
	end

	logic unused_top;
	assign unused_top = ^{cpu_q, ent_raw_q, scan_cpu};

	`LTLM_ASSERT_IMP(a_out_no_in, clk, arst_n, out_valid, !in_ready)
	`LTLM_ASSERT_IMP(a_inc_found, clk, arst_n, inc, eng_ok && st_q == T_WAIT)
	`LTLM_ASSERT_NXT(a_pop_chosen, clk, arst_n,
		out_valid && req_q != ltlm_pkg::REQ_ADMIT, chosen_q == '0 || !out_valid)
endmodule

[hw/rtl/ltlm_min_finder.sv]
module ltlm_min_finder #(
	parameter int NUM_CPUS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [ltlm_pkg::COUNT_W-1:0] count_in,
	input  logic inc,
	input  logic [$clog2(NUM_CPUS+1)-1:0] inc_cpu,
	output logic [$clog2(NUM_CPUS+1)-1:0] scan_cpu,
	output logic busy,
	output logic [$clog2(NUM_CPUS+1)-1:0] best_cpu
);
	localparam int CW = $clog2(NUM_CPUS+1);
	localparam int IW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

	logic [ltlm_pkg::COUNT_W-1:0] cnt_q [NUM_CPUS];
	logic [ltlm_pkg::COUNT_W-1:0] best_val_q;
	logic [CW-1:0] idx_q;
	logic busy_q;
	logic [CW-1:0] best_q;
	logic [ltlm_pkg::COUNT_W-1:0] cur_val;

	assign cur_val  = cnt_q[idx_q[IW-1:0]];
	assign scan_cpu = idx_q;
	assign busy     = busy_q;
	assign best_cpu = best_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			best_q <= '0;
			best_val_q <= '0;
			for (int i = 0; i < NUM_CPUS; i++) cnt_q[i] <= '0;
		end else begin
			if (inc) cnt_q[inc_cpu[IW-1:0]] <= cnt_q[inc_cpu[IW-1:0]] + 1'b1;
			if (start) begin
				busy_q <= 1'b1;
				idx_q <= '0;
				best_q <= '0;
				best_val_q <= cnt_q[0];
			end else if (busy_q) begin
				if (cur_val < best_val_q) begin
					best_val_q <= cur_val;
					best_q <= idx_q;
				end
				if (idx_q == CW'(NUM_CPUS - 1)) busy_q <= 1'b0;
				else idx_q <= idx_q + 1'b1;
			end
		end
	end

	logic unused_cnt;
	assign unused_cnt = ^count_in;
endmodule

[hw/rtl/ltlm_list_engine.sv]
module ltlm_list_engine #(
	parameter int NUM_ENTRIES = 64,
	parameter int NUM_CPUS = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] op,
	input  logic [$clog2(NUM_CPUS+3)-1:0] slot,
	input  logic [$clog2(NUM_ENTRIES+1)-1:0] ent,
	output logic done,
	output logic ok,
	output logic [$clog2(NUM_ENTRIES+1)-1:0] popped
);
	localparam int LW = $clog2(NUM_ENTRIES+1);
	localparam int AW = $clog2(NUM_ENTRIES);
	localparam int NL = NUM_CPUS + 3;
	localparam int SW = $clog2(NL);
	localparam logic [LW-1:0] NIL = LW'(NUM_ENTRIES);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_CHK  = 3'd2;
	localparam logic [2:0] ST_WR2  = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [LW-1:0] head_q [NL];
	logic [LW-1:0] mem [NUM_ENTRIES];
	logic [LW-1:0] rd_q;
	logic [AW-1:0] rd_addr;
	logic rd_en;
	logic we;
	logic [AW-1:0] wa;
	logic [LW-1:0] wd;

	logic [2:0] st_q;
	logic [1:0] op_q;
	logic [SW-1:0] slot_q;
	logic [LW-1:0] ent_q, cur_q, prev_q, nxt_q;
	logic [LW:0] steps_q;
	logic ok_q, first_q;
	logic [LW-1:0] pop_q;
	logic clr_q;
	logic [AW-1:0] clr_idx_q;

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (rd_en) rd_q <= mem[rd_addr];
	end

	assign done = (st_q == ST_DONE);
	assign ok = ok_q;
	assign popped = pop_q;

	always_comb begin
		rd_en = 1'b0;
		rd_addr = cur_q[AW-1:0];
		we = 1'b0;
		wa = cur_q[AW-1:0];
		wd = ent_q;
		if (clr_q) begin
			we = 1'b1;
			wa = clr_idx_q;
			wd = LW'(clr_idx_q) + 1'b1;
		end else begin
			unique case (st_q)
				ST_RD: rd_en = 1'b1;
				ST_CHK: begin
					if ((op_q == ltlm_pkg::REQ_APPEND || op_q == ltlm_pkg::REQ_ADMIT)
						&& rd_q == NIL) begin
						we = 1'b1;
						wa = cur_q[AW-1:0];
						wd = ent_q;
					end else if (op_q == ltlm_pkg::REQ_POP) begin
						we = 1'b1;
						wa = cur_q[AW-1:0];
						wd = NIL;
					end else if (op_q == ltlm_pkg::REQ_UNLINK && cur_q == ent_q) begin
						we = 1'b1;
						wa = cur_q[AW-1:0];
						wd = NIL;
					end
				end
				ST_WR2: begin
					we = 1'b1;
					wa = prev_q[AW-1:0];
					wd = nxt_q;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			clr_q <= 1'b1;
			clr_idx_q <= '0;
			ok_q <= 1'b0;
			for (int i = 0; i < NL; i++) head_q[i] <= (i == NL - 1) ? '0 : NIL;
		end else if (clr_q) begin
			if (clr_idx_q == AW'(NUM_ENTRIES - 1)) clr_q <= 1'b0;
			else clr_idx_q <= clr_idx_q + 1'b1;
		end else begin
			unique case (st_q)
				ST_IDLE: if (start) begin
					op_q <= op;
					slot_q <= slot;
					ent_q <= ent;
					ok_q <= (head_q[slot] == NIL)
						&& (op == ltlm_pkg::REQ_APPEND || op == ltlm_pkg::REQ_ADMIT);
					pop_q <= '0;
					steps_q <= '0;
					first_q <= 1'b1;
					cur_q <= head_q[slot];
					if (head_q[slot] == NIL) begin
						if (op == ltlm_pkg::REQ_APPEND || op == ltlm_pkg::REQ_ADMIT)
							head_q[slot] <= ent;
						st_q <= ST_DONE;
					end else st_q <= ST_RD;
				end
				ST_RD: st_q <= ST_CHK;
				ST_CHK: begin
					priority if (op_q == ltlm_pkg::REQ_POP) begin
						head_q[slot_q] <= rd_q;
						pop_q <= cur_q;
						ok_q <= 1'b1;
						st_q <= ST_DONE;
					end else if (op_q == ltlm_pkg::REQ_UNLINK) begin
						if (cur_q == ent_q) begin
							ok_q <= 1'b1;
							if (first_q) begin
								head_q[slot_q] <= rd_q;
								st_q <= ST_DONE;
							end else begin
								nxt_q <= rd_q;
								st_q <= ST_WR2;
							end
						end else if (rd_q == NIL || (!first_q && steps_q == (LW+1)'(NUM_ENTRIES))) begin
							st_q <= ST_DONE;
						end else begin
							if (!first_q) steps_q <= steps_q + 1'b1;
							first_q <= 1'b0;
							prev_q <= cur_q;
							cur_q <= rd_q;
							st_q <= ST_RD;
						end
					end else begin
						if (rd_q == NIL) begin
							ok_q <= 1'b1;
							st_q <= ST_DONE;
						end else if (steps_q == (LW+1)'(NUM_ENTRIES)) begin
							st_q <= ST_DONE;
						end else begin
							steps_q <= steps_q + 1'b1;
							cur_q <= rd_q;
							st_q <= ST_RD;
						end
					end
				end
				ST_WR2: st_q <= ST_DONE;
				ST_DONE: st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[tb/tb_linked_task_list_manager_top.sv]
`timescale 1ns / 100ps

module tb_linked_task_list_manager_top;
	import ltlm_pkg::*;

	localparam int NUM_ENTRIES = 64;
	localparam int NUM_CPUS = 8;
	localparam int NUM_LISTS = NUM_CPUS + 3;
	localparam logic [6:0] NIL = 7'(NUM_ENTRIES);
	localparam logic [1:0] KIND_ZOMBIE = 2'd1;
	localparam logic [1:0] KIND_SLEEP = 2'd2;
	localparam logic [1:0] KIND_FREE = 2'd3;
	localparam int DETACHED = 15;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int PHASE_ITEMS = 325;
	localparam int NUM_PHASES = 6;
	localparam int DRAIN_CYCLES = 2 * NUM_ENTRIES + 40;

	typedef struct {
		logic found;
		logic [ENTF_W-1:0] entry;
		logic [CPUF_W-1:0] cpu;
	} task_result_t;

	typedef struct {
		logic [REQ_W-1:0] req;
		logic [KIND_W-1:0] kind;
		logic [CPUF_W-1:0] cpu;
		logic [ENTF_W-1:0] ent;
		bit chk;
		task_result_t res;
	} request_row_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [REQ_W-1:0] req_type = '0;
	logic [KIND_W-1:0] list_kind = '0;
	logic [CPUF_W-1:0] cpu_index = '0;
	logic [ENTF_W-1:0] entry_index = '0;
	logic out_valid;
	logic out_ready = 0;
	logic found;
	logic [ENTF_W-1:0] entry_out;
	logic [CPUF_W-1:0] chosen_cpu;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic cfg_data = 0;

	linked_task_list_manager_top #(.NUM_ENTRIES(NUM_ENTRIES), .NUM_CPUS(NUM_CPUS)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .list_kind(list_kind), .cpu_index(cpu_index),
		.entry_index(entry_index),
		.out_valid(out_valid), .out_ready(out_ready),
		.found(found), .entry_out(entry_out), .chosen_cpu(chosen_cpu),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// shadow of the list state
	logic [6:0] heads [NUM_LISTS];
	logic [6:0] links [NUM_ENTRIES];
	logic [COUNT_W-1:0] adm_cnt [NUM_CPUS];
	logic balance;
	int where_is [NUM_ENTRIES];

	task_result_t expected_results[$];
	int errors = 0;
	int results_seen = 0;
	int items_sent = 0;
	int admits_done = 0;
	int pops_done = 0;
	int unlinks_done = 0;
	int cycles = 0;
	bit hold_req = 0;

	function automatic int slot_of(logic [1:0] kind, logic [2:0] cpu);
		if (kind == KIND_READY)
			return (int'(cpu) < NUM_CPUS) ? int'(cpu) : -1;
		return NUM_CPUS + int'(kind) - 1;
	endfunction

	function automatic bit list_append(int slot, logic [6:0] e);
		logic [6:0] cur;
		int steps;
		cur = heads[slot];
		steps = 0;
		if (cur == NIL) begin
			heads[slot] = e;
			return 1;
		end
		while (links[cur] != NIL && steps < NUM_ENTRIES) begin
			cur = links[cur];
			steps++;
		end
		if (links[cur] != NIL)
			return 0;
		links[cur] = e;
		return 1;
	endfunction

	function automatic bit list_unlink(int slot, logic [6:0] e);
		logic [6:0] prv, cur;
		int steps;
		steps = 0;
		if (heads[slot] == NIL)
			return 0;
		if (heads[slot] == e) begin
			heads[slot] = links[e];
			links[e] = NIL;
			return 1;
		end
		prv = heads[slot];
		cur = links[prv];
		while (cur != NIL && steps < NUM_ENTRIES) begin
			if (cur == e) begin
				links[prv] = links[cur];
				links[cur] = NIL;
				return 1;
			end
			prv = cur;
			cur = links[cur];
			steps++;
		end
		return 0;
	endfunction

	function automatic task_result_t apply_request(logic [1:0] req, logic [1:0] kind,
			logic [2:0] cpu, logic [5:0] ent);
		task_result_t r;
		int slot, target;
		logic [6:0] h;
		r.found = 0;
		r.entry = ent;
		r.cpu = '0;
		if (req == REQ_POP) begin
			r.entry = '0;
			slot = slot_of(kind, cpu);
			if (slot >= 0 && heads[slot] != NIL) begin
				h = heads[slot];
				heads[slot] = links[h];
				links[h] = NIL;
				r.found = 1;
				r.entry = h[5:0];
				where_is[h] = DETACHED;
				pops_done++;
			end
		end else if (req == REQ_APPEND || req == REQ_UNLINK) begin
			slot = slot_of(kind, cpu);
			if (slot >= 0) begin
				if (req == REQ_APPEND && list_append(slot, {1'b0, ent})) begin
					r.found = 1;
					where_is[ent] = slot;
				end else if (req == REQ_UNLINK && list_unlink(slot, {1'b0, ent})) begin
					r.found = 1;
					where_is[ent] = DETACHED;
					unlinks_done++;
				end
			end
		end else begin
			target = -1;
			if (balance) begin
				target = 0;
				for (int i = 1; i < NUM_CPUS; i++)
					if (adm_cnt[i] < adm_cnt[target])
						target = i;
			end else if (int'(cpu) < NUM_CPUS) begin
				target = int'(cpu);
			end
			if (target >= 0 && list_append(target, {1'b0, ent})) begin
				adm_cnt[target] = adm_cnt[target] + 1;
				r.found = 1;
				r.cpu = 3'(target);
				where_is[ent] = target;
				admits_done++;
			end
		end
		return r;
	endfunction

	task automatic send_request(logic [1:0] req, logic [1:0] kind, logic [2:0] cpu,
			logic [5:0] ent, bit chk, task_result_t typed);
		task_result_t r;
		@(negedge clk);
		in_valid = 1;
		req_type = req;
		list_kind = kind;
		cpu_index = cpu;
		entry_index = ent;
		do @(posedge clk); while (!in_ready);
		r = apply_request(req, kind, cpu, ent);
		expected_results.push_back(chk ? typed : r);
		items_sent++;
	endtask

	task automatic idle_input();
		@(negedge clk);
		in_valid = 0;
	endtask

	task automatic write_balance(logic v);
		@(negedge clk);
		cfg_valid = 1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		balance = v;
		@(negedge clk);
		cfg_valid = 0;
	endtask

	task automatic wait_drained();
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_request();
		logic [1:0] req, kind;
		logic [2:0] cpu;
		logic [5:0] ent;
		int pick, s;
		int free_ents[$];
		int listed[$];
		task_result_t none;
		none = '{0, 0, 0};
		req = 2'($urandom);
		kind = 2'($urandom);
		cpu = 3'($urandom);
		ent = 6'($urandom);
		pick = $urandom_range(0, 99);
		if (pick >= 12) begin
			for (int i = 0; i < NUM_ENTRIES; i++)
				if (where_is[i] == DETACHED)
					free_ents.push_back(i);
				else
					listed.push_back(i);
			if (free_ents.size() != 0 && pick < 55) begin
				ent = 6'(free_ents[$urandom_range(0, free_ents.size() - 1)]);
				req = ($urandom_range(0, 2) == 0) ? REQ_ADMIT : REQ_APPEND;
			end else if (listed.size() != 0 && pick < 72) begin
				ent = 6'(listed[$urandom_range(0, listed.size() - 1)]);
				s = where_is[ent];
				req = REQ_UNLINK;
				if (s < NUM_CPUS) begin
					kind = KIND_READY;
					cpu = 3'(s);
				end else begin
					kind = 2'(s - NUM_CPUS + 1);
				end
			end else begin
				req = REQ_POP;
				if ($urandom_range(0, 2) == 0)
					kind = KIND_FREE;
			end
		end
		send_request(req, kind, cpu, ent, 0, none);
	endtask

	request_row_t directed [] = '{
		'{REQ_POP, KIND_FREE, 3'd0, 6'd0, 1, '{1, 6'd0, 3'd0}},
		'{REQ_POP, KIND_ZOMBIE, 3'd7, 6'd63, 1, '{0, 6'd0, 3'd0}},
		'{REQ_APPEND, KIND_ZOMBIE, 3'd0, 6'd0, 0, '{0, 0, 0}},
		'{REQ_POP, KIND_FREE, 3'd5, 6'd0, 1, '{1, 6'd1, 3'd0}},
		'{REQ_APPEND, KIND_READY, 3'd7, 6'd1, 0, '{0, 0, 0}},
		'{REQ_UNLINK, KIND_READY, 3'd7, 6'd63, 1, '{0, 6'd63, 3'd0}},
		'{REQ_UNLINK, KIND_READY, 3'd7, 6'd1, 0, '{0, 0, 0}},
		'{REQ_ADMIT, KIND_FREE, 3'd7, 6'd1, 1, '{1, 6'd1, 3'd7}},
		'{REQ_POP, KIND_ZOMBIE, 3'd0, 6'd0, 0, '{0, 0, 0}},
		'{REQ_ADMIT, KIND_READY, 3'd0, 6'd0, 0, '{0, 0, 0}},
		'{REQ_POP, KIND_READY, 3'd0, 6'd42, 0, '{0, 0, 0}},
		'{REQ_UNLINK, KIND_FREE, 3'd3, 6'd63, 0, '{0, 0, 0}},
		'{REQ_APPEND, KIND_FREE, 3'd0, 6'd63, 0, '{0, 0, 0}},
		'{REQ_APPEND, KIND_SLEEP, 3'd5, 6'd0, 0, '{0, 0, 0}},
		'{REQ_POP, KIND_SLEEP, 3'd2, 6'd21, 0, '{0, 0, 0}},
		'{REQ_UNLINK, KIND_SLEEP, 3'd0, 6'd0, 1, '{0, 6'd0, 3'd0}},
		'{REQ_POP, KIND_READY, 3'd7, 6'd0, 0, '{0, 0, 0}},
		'{REQ_ADMIT, KIND_ZOMBIE, 3'd6, 6'd63, 0, '{0, 0, 0}}
	};

	// result checker
	always @(posedge clk) begin
		task_result_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected transaction: found=%0d entry=%0d cpu=%0d",
						found, entry_out, chosen_cpu);
			end else begin
				e = expected_results.pop_front();
				if (found !== e.found || entry_out !== e.entry || chosen_cpu !== e.cpu) begin
					errors++;
					if (errors <= 10)
						$display("mismatch at result %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
							results_seen, e.found, e.entry, e.cpu,
							found, entry_out, chosen_cpu);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("linked_task_list_manager_top regression: fail");
			$finish;
		end
	end

	// receiver stall patterns
	initial begin
		int style, left, tick;
		style = 0;
		left = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 0;
				out_ready = 0;
				repeat (400) @(negedge clk);
			end
			if (left == 0) begin
				style = $urandom_range(0, 2);
				left = $urandom_range(20, 120);
			end
			left--;
			tick++;
			case (style)
				0: out_ready = 1;
				1: out_ready = $urandom_range(0, 1);
				default: out_ready = (tick % 4) != 0;
			endcase
		end
	end

	initial begin
		int burst;
		task_result_t r;
		for (int i = 0; i < NUM_LISTS; i++)
			heads[i] = NIL;
		heads[NUM_CPUS + 2] = 0;
		for (int i = 0; i < NUM_ENTRIES; i++) begin
			links[i] = 7'(i + 1);
			where_is[i] = NUM_CPUS + 2;
		end
		for (int i = 0; i < NUM_CPUS; i++)
			adm_cnt[i] = '0;
		balance = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		write_balance(0);
		foreach (directed[i]) begin
			r = directed[i].res;
			send_request(directed[i].req, directed[i].kind, directed[i].cpu,
				directed[i].ent, directed[i].chk, r);
		end
		idle_input();
		wait_drained();

		for (int p = 0; p < NUM_PHASES; p++) begin
			write_balance(p % 2 == 0);
			for (int n = 0; n < PHASE_ITEMS; ) begin
				burst = $urandom_range(1, 24);
				for (int b = 0; b < burst && n < PHASE_ITEMS; b++, n++) begin
					if (p == 2 && n == 100)
						hold_req = 1;
					random_request();
				end
				if ($urandom_range(0, 3) != 0) begin
					idle_input();
					repeat ($urandom_range(0, 10)) @(negedge clk);
				end
			end
			idle_input();
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			errors += expected_results.size();
			$display("%0d results never arrived", expected_results.size());
		end
		$display("%0d requests over %0d balance phases: %0d pops, %0d unlinks, %0d admits hit",
			items_sent, NUM_PHASES, pops_done, unlinks_done, admits_done);
		$display("%0d results checked, %0d mismatches, %0d cycles", results_seen, errors, cycles);
		if (errors == 0)
			$display("linked_task_list_manager_top regression: pass");
		else
			$display("linked_task_list_manager_top regression: fail");
		$finish;
	end
endmodule
